// ===== hw/rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int HASH_BITS_DEF = 8;

  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 31;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_KEY  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic check;
  } lpht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic early;
    logic done;
  } lpht_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl
  import lpht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire lpht_stat_t stat,
  output lpht_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start && !stat.early) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = stat.done ? S_IDLE : S_READ;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy           = (state_r != S_IDLE);
    cmd.clear_step = (state_r == S_CLEAR);
    cmd.load       = (state_r == S_IDLE) && start;
    cmd.check      = (state_r == S_CHECK);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lpht_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp
  import lpht_pkg::*;
#(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lpht_cmd_t           cmd,
  output lpht_stat_t               stat,
  input  wire logic                in_opcode,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [SIZE_W-1:0]   in_size_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [SIZE_W-1:0]        out_found_size,
  output logic [COUNT_W-1:0]       out_entry_count
);

  localparam int SLOTS = 1 << HASH_BITS;

  // table memory
  logic [KEY_W-1:0]  key_mem  [SLOTS];
  logic [SIZE_W-1:0] size_mem [SLOTS];

  logic                 op_r;
  logic [KEY_W-1:0]     key_r;
  logic [SIZE_W-1:0]    size_r;
  logic [HASH_BITS-1:0] addr_r;
  logic [HASH_BITS-1:0] probes_r;
  logic [HASH_BITS-1:0] clr_addr_r;
  logic [HASH_BITS:0]   count_r;
  logic [KEY_W-1:0]     rd_key_r;
  logic [SIZE_W-1:0]    rd_size_r;

  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [SIZE_W-1:0]    out_found_size_r;
  logic [COUNT_W-1:0]   out_entry_count_r;

  logic                 full;
  logic                 in_key_zero;
  logic                 slot_empty;
  logic                 key_match;
  logic                 lap_end;
  logic                 ins_hit;
  logic [HASH_BITS:0]   count_inc;
  logic [HASH_BITS+8:0] slot_wide;
  logic [HASH_BITS+8:0] count_wide;
  logic [HASH_BITS+8:0] count_inc_wide;
  logic                 we;
  logic [HASH_BITS-1:0] wa;
  logic [KEY_W-1:0]     wd_key;
  logic [SIZE_W-1:0]    wd_size;

  // count never exceeds the slot count, so its top bit means full
  assign full           = count_r[HASH_BITS];
  assign in_key_zero    = (in_key == '0);
  assign slot_empty     = (rd_key_r == '0);
  assign key_match      = (rd_key_r == key_r);
  assign lap_end        = (probes_r == '1);
  assign ins_hit        = (op_r == OP_INSERT) && slot_empty;
  assign count_inc      = count_r + 1'b1;
  assign slot_wide      = {9'd0, addr_r};
  assign count_wide     = {8'd0, count_r};
  assign count_inc_wide = {8'd0, count_inc};

  assign stat.clear_last = (clr_addr_r == '1);
  assign stat.early      = in_key_zero || ((in_opcode == OP_INSERT) && full);
  assign stat.done       = (op_r == OP_INSERT) ? (slot_empty || lap_end)
                         : (key_match || slot_empty || (rd_size_r == '0) || lap_end);

  assign we      = cmd.clear_step || (cmd.check && ins_hit);
  assign wa      = cmd.clear_step ? clr_addr_r : addr_r;
  assign wd_key  = cmd.clear_step ? '0 : key_r;
  assign wd_size = cmd.clear_step ? '0 : size_r;

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wa]  <= wd_key;
      size_mem[wa] <= wd_size;
    end
    rd_key_r  <= key_mem[addr_r];
    rd_size_r <= size_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.clear_step) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.load && stat.early) out_valid_r <= 1'b1;
      if (cmd.check && stat.done) out_valid_r <= 1'b1;
      if (cmd.check && ins_hit) count_r <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      key_r    <= in_key;
      size_r   <= in_size_value;
      addr_r   <= in_key[HASH_BITS-1:0];
      probes_r <= '0;
      if (stat.early) begin
        out_status_r      <= in_key_zero ? ST_ZERO_KEY : ST_FULL;
        out_slot_r        <= '0;
        out_found_size_r  <= '0;
        out_entry_count_r <= count_wide[COUNT_W-1:0];
      end
    end else if (cmd.check) begin
      if (stat.done) begin
        out_slot_r        <= '0;
        out_found_size_r  <= '0;
        out_entry_count_r <= count_wide[COUNT_W-1:0];
        if (op_r == OP_INSERT) begin
          if (slot_empty) begin
            out_status_r      <= ST_INSERTED;
            out_slot_r        <= slot_wide[SLOT_W-1:0];
            out_entry_count_r <= count_inc_wide[COUNT_W-1:0];
          end else begin
            out_status_r <= ST_FULL;
          end
        end else if (key_match) begin
          out_status_r     <= ST_FOUND;
          out_slot_r       <= slot_wide[SLOT_W-1:0];
          out_found_size_r <= rd_size_r;
        end else begin
          out_status_r <= ST_NOT_FOUND;
        end
      end else begin
        addr_r   <= addr_r + 1'b1;
        probes_r <= probes_r + 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_found_size  = out_found_size_r;
  assign out_entry_count = out_entry_count_r;

endmodule

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Results: a zero key or a full-table insert gives its result in the cycle after start;
// otherwise each probed slot, 1 to 2^HASH_BITS of them, takes a registered table
// read and then a compare.
// Throughput: one operation at a time; start is taken again once busy drops.
// Reset: synchronous, active low; a clearing pass then zeroes every slot, one slot
// per cycle, with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command channel: transfer when start is high and busy is low
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_opcode,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [SIZE_W-1:0]   in_size_value,
  // result channel: one-cycle strobe, always taken
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [SIZE_W-1:0]        out_found_size,
  output logic [COUNT_W-1:0]       out_entry_count
);

  // Command and status between the sequencer and the table datapath.
  lpht_cmd_t  cmd;
  lpht_stat_t stat;

  // Sequencer: clear pass after reset, then idle / read / check per probe.
  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath: table memory, probe address and lap counter, entry count,
  // and the registered result that is strobed out for one cycle.
  lpht_dp #(
    .HASH_BITS (HASH_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_size_value   (in_size_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_found_size  (out_found_size),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire
